>>> design/u16u8_pkg.sv
package u16u8_pkg;

   localparam logic [5:0]  HIGH_TAG     = 6'b110110;
   localparam logic [5:0]  LOW_TAG      = 6'b110111;
   localparam logic [10:0] PLANE_OFFSET = 11'h040;
   localparam logic [20:0] MAX_ONE      = 21'h00007F;
   localparam logic [20:0] MAX_TWO      = 21'h0007FF;
   localparam logic [20:0] MAX_THREE    = 21'h00FFFF;
   localparam logic [7:0]  LEAD_TWO     = 8'hC0;
   localparam logic [7:0]  LEAD_THREE   = 8'hE0;
   localparam logic [7:0]  LEAD_FOUR    = 8'hF0;
   localparam logic [7:0]  CONT_MARK    = 8'h80;
   localparam int          JOB_BYTES    = 6;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        end_of_string;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] utf8_byte;
      logic       last_of_run;
      logic       string_done;
   } rsp_payload_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      len;
   } enc_type;

   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] bytes;
      logic [2:0]                count;
      logic                      eos;
   } job_type;

   function automatic enc_type encode(input logic [20:0] cp);
      enc_type r;
      r = '0;
      if (cp <= MAX_ONE) begin
         r.bytes[0] = cp[7:0];
         r.len      = 3'd1;
      end else if (cp <= MAX_TWO) begin
         r.bytes[0] = LEAD_TWO | {3'b000, cp[10:6]};
         r.bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
         r.len      = 3'd2;
      end else if (cp <= MAX_THREE) begin
         r.bytes[0] = LEAD_THREE | {4'b0000, cp[15:12]};
         r.bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
         r.bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
         r.len      = 3'd3;
      end else begin
         r.bytes[0] = LEAD_FOUR | {5'b00000, cp[20:18]};
         r.bytes[1] = CONT_MARK | {2'b00, cp[17:12]};
         r.bytes[2] = CONT_MARK | {2'b00, cp[11:6]};
         r.bytes[3] = CONT_MARK | {2'b00, cp[5:0]};
         r.len      = 3'd4;
      end
      return r;
   endfunction

endpackage

>>> design/u16u8_front.sv
module u16u8_front import u16u8_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            push_ready,
   output logic            push_valid,
   output job_type         push_job
);

   logic       held_ff, held_in;
   logic [9:0] held_bits_ff, held_bits_in;
   logic       accept, is_high, is_low, pair, en_a, en_b;
   logic [20:0] cp_a, cp_b;
   enc_type    enc_a, enc_b;
   job_type    job;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;
   assign is_high   = req_payload.code_unit[15:10] == HIGH_TAG;
   assign is_low    = req_payload.code_unit[15:10] == LOW_TAG;
   assign pair      = held_ff && is_low;
   assign en_a      = held_ff;
   assign en_b      = !pair && !(is_high && !req_payload.end_of_string);

   assign cp_a  = pair ? {{1'b0, held_bits_ff} + PLANE_OFFSET, req_payload.code_unit[9:0]}
                       : {5'b00000, HIGH_TAG, held_bits_ff};
   assign cp_b  = {5'b00000, req_payload.code_unit};
   assign enc_a = encode(cp_a);
   assign enc_b = encode(cp_b);

   always_comb begin
      job     = '0;
      job.eos = req_payload.end_of_string;
      if (en_a && en_b) begin
         // held surrogate alone is always three bytes, unit follows it
         job.bytes[2:0] = enc_a.bytes[2:0];
         job.bytes[5:3] = enc_b.bytes[2:0];
         job.count      = 3'd3 + enc_b.len;
      end else if (en_a) begin
         job.bytes[3:0] = enc_a.bytes;
         job.count      = enc_a.len;
      end else if (en_b) begin
         job.bytes[3:0] = enc_b.bytes;
         job.count      = enc_b.len;
      end
   end

   assign push_valid = req_valid && (en_a || en_b);
   assign push_job   = job;

   always_comb begin
      held_in      = held_ff;
      held_bits_in = held_bits_ff;
      if (accept) begin
         held_in      = is_high && !req_payload.end_of_string && !pair;
         held_bits_in = req_payload.code_unit[9:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
      end else begin
         held_ff <= held_in;
      end
      held_bits_ff <= held_bits_in;
   end

endmodule

>>> design/u16u8_queue.sv
module u16u8_queue import u16u8_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_job
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> design/u16u8_back.sv
module u16u8_back import u16u8_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            pop_valid,
   output logic            pop_ready,
   input  job_type         pop_job,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic [2:0]      idx_ff, idx_in;
   logic            out_free, emit, last;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit      = out_free && pop_valid;
   assign last      = idx_ff == pop_job.count - 3'd1;
   assign pop_ready = emit && last;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      idx_in         = idx_ff;
      if (out_free) begin
         rsp_valid_in = emit;
      end
      if (emit) begin
         rsp_payload_in.utf8_byte   = pop_job.bytes[idx_ff];
         rsp_payload_in.last_of_run = last;
         rsp_payload_in.string_done = last && pop_job.eos;
         idx_in                     = last ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 3'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

>>> design/utf16le_to_utf8_transcoder.sv
// path: a code unit's output bytes are registered in the job queue, then in the output register
// throughput: one output byte per cycle from the byte serialiser unless rsp_ready stalls
//    it; a unit yields 0 to 6 bytes, and a new unit is taken every cycle while the
//    two-entry job queue has room
// reset: synchronous, clears the held-surrogate flag, the queue and the output valid flag
module utf16le_to_utf8_transcoder import u16u8_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic    push_valid, push_ready, pop_valid, pop_ready;
   job_type push_job, pop_job;

   u16u8_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_ready  (push_ready),
      .push_valid  (push_valid),
      .push_job    (push_job)
   );

   u16u8_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   u16u8_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_job     (pop_job),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
